### hw/rtl/url_pd_pkg.sv
package url_pd_pkg;

    localparam int unsigned MaxRes = 3;

    localparam logic [7:0] ChPercent = 8'h25;
    localparam logic [7:0] ChPlus    = 8'h2B;
    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] PrintLo   = 8'd32;
    localparam logic [7:0] PrintHi   = 8'd126;

    // Escape tracking, one-hot
    typedef enum logic [2:0] {
        PH_NONE = 3'b001,
        PH_PCT  = 3'b010,
        PH_DIG  = 3'b100
    } t_phase;

    // Result bytes caused by one input beat
    typedef struct packed {
        logic [MaxRes-1:0][7:0] bytes;
        logic [1:0]             cnt;
        logic                   bare;
        logic                   str_end;
    } t_res_set;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                 (c >= 8'h61 && c <= 8'h66);
    endfunction

    // Nibble of a hex digit character, either case
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] t;
        if (c <= 8'h39) begin
            t = c - 8'h30;
        end else if (c >= 8'h61) begin
            t = c - 8'h61 + 8'd10;
        end else begin
            t = c - 8'h41 + 8'd10;
        end
        hex_value = t[3:0];
    endfunction

endpackage

### hw/rtl/url_pd_core.sv
module url_pd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_in_byte,
    input  logic                i_string_last,
    output url_pd_pkg::t_res_set o_set
);
    import url_pd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    t_res_set   s_set;
    logic [7:0] s_dec;
    logic [7:0] s_fresh;

    assign s_dec   = {hex_value(r_held), hex_value(i_in_byte)};
    assign s_fresh = (i_in_byte == ChPlus) ? ChSpace : i_in_byte;

    // Build the result list for this beat and the next escape state
    always_comb begin
        n_phase       = PH_NONE;
        n_held        = r_held;
        s_set         = '0;
        s_set.str_end = i_string_last;
        case (r_phase)
            PH_PCT: begin
                if (is_hex(i_in_byte)) begin
                    n_held  = i_in_byte;
                    n_phase = PH_DIG;
                end else begin
                    s_set.bytes[0] = ChPercent;
                    s_set.cnt      = 2'd1;
                    if (i_in_byte == ChPercent) begin
                        n_phase = PH_PCT;
                    end else begin
                        s_set.bytes[1] = s_fresh;
                        s_set.cnt      = 2'd2;
                    end
                end
            end
            PH_DIG: begin
                if (is_hex(i_in_byte)) begin
                    if (s_dec >= PrintLo && s_dec <= PrintHi) begin
                        s_set.bytes[0] = s_dec;
                        s_set.cnt      = 2'd1;
                    end
                end else begin
                    s_set.bytes[0] = ChPercent;
                    s_set.bytes[1] = r_held;
                    s_set.cnt      = 2'd2;
                    if (i_in_byte == ChPercent) begin
                        n_phase = PH_PCT;
                    end else begin
                        s_set.bytes[2] = s_fresh;
                        s_set.cnt      = 2'd3;
                    end
                end
            end
            default: begin
                if (i_in_byte == ChPercent) begin
                    n_phase = PH_PCT;
                end else begin
                    s_set.bytes[0] = s_fresh;
                    s_set.cnt      = 2'd1;
                end
            end
        endcase

        // Flush held lookahead at string end
        if (i_string_last) begin
            case (n_phase)
                PH_PCT: begin
                    s_set.bytes[s_set.cnt] = ChPercent;
                    s_set.cnt              = s_set.cnt + 2'd1;
                end
                PH_DIG: begin
                    s_set.bytes[0] = ChPercent;
                    s_set.bytes[1] = n_held;
                    s_set.cnt      = 2'd2;
                end
                default: begin
                end
            endcase
            n_phase = PH_NONE;
            if (s_set.cnt == 2'd0) begin
                s_set.cnt  = 2'd1;
                s_set.bare = 1'b1;
            end
        end
    end

    assign o_set = s_set;

    // Advance escape state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NONE;
            r_held  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_string_last) |=> (r_phase == PH_NONE))
        else $error("escape state survives string end");

    a_bare_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_set.bare |-> (s_set.cnt == 2'd1 && s_set.str_end))
        else $error("end marker mixed with bytes");

endmodule

### hw/rtl/url_pd_out.sv
module url_pd_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  url_pd_pkg::t_res_set i_set,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_byte_valid,
    output logic                 o_run_last,
    output logic                 o_string_end
);
    import url_pd_pkg::*;

    t_res_set   r_set;
    logic       r_valid;
    logic [1:0] r_idx;
    logic       s_last;
    logic       s_done;

    assign s_last = (r_idx == r_set.cnt - 2'd1);
    assign s_done = r_valid && i_ready && s_last;
    assign o_free = !r_valid || s_done;

    assign o_valid      = r_valid;
    assign o_out_byte   = r_set.bare ? 8'd0 : r_set.bytes[r_idx];
    assign o_byte_valid = !r_set.bare;
    assign o_run_last   = s_last;
    assign o_string_end = s_last && r_set.str_end;

    // Hold the result set and drain one beat per handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load && o_free && i_set.cnt != 2'd0) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (s_done) begin
            r_valid <= 1'b0;
        end else if (r_valid && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_set <= i_set;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_set.cnt != 2'd0 && r_idx < r_set.cnt))
        else $error("drain index past result count");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_free) |=> (r_valid && $stable(r_set)))
        else $error("pending set lost while busy");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_string_end) |-> o_run_last)
        else $error("string end before last result");

endmodule

### hw/rtl/url_percent_decoder.sv
// Channel | Direction | Handshake               | Payload
// input   | in        | i_in_valid / o_in_ready | i_in_byte, i_string_last
// output  | out       | o_out_valid/i_out_ready | o_out_byte, o_byte_valid,
//         |           |                         | o_run_last, o_string_end
//
// One input beat is decoded in the cycle it is accepted; its results (one to
// three, or none) land in the output register the next cycle.
// Sustained rate: one input beat per cycle while each beat gives at most one
// result and the output side does not stall; a beat with several results
// keeps o_in_ready low until its final result is taken.
// o_in_ready follows i_out_ready combinationally on the final result beat.
// Reset (synchronous, active low) clears the escape state and output valid.
module url_percent_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_string_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_run_last,
    output logic       o_string_end
);
    import url_pd_pkg::*;

    t_res_set s_set;
    logic     s_free;
    logic     s_accept;

    assign o_in_ready = s_free;
    assign s_accept   = i_in_valid && s_free;

    url_pd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_accept),
        .i_in_byte     (i_in_byte),
        .i_string_last (i_string_last),
        .o_set         (s_set)
    );

    url_pd_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (s_accept),
        .i_set        (s_set),
        .o_free       (s_free),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

endmodule
